// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the contour tracer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CCCT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("ccct assertion failed");

// Next-cycle implication, disabled in reset.
`define CCCT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("ccct assertion failed");

`endif

// ===== design/ccct_pkg.sv =====
// ----------------------------------------------------------------------------
// ccct_pkg
// Types, codes and direction tables for the chain code contour tracer.
// ----------------------------------------------------------------------------
package ccct_pkg;

    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 64;
    localparam int PIXEL_BITS_DEF = 8;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CMD_W     = 2;
    localparam int PIX_IN_W  = 8;
    localparam int DIR_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int ROW_OUT_W = 6;
    localparam int COL_OUT_W = 6;
    localparam int LABEL_W   = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEW  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_STEP      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLOSE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_OBJECT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ISOLATED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FINISHED  = 3'd4;

    localparam logic [DIR_W-1:0] DIR_RESET = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [PIX_IN_W-1:0] pixel_value;
    } req_t;

    typedef struct packed {
        logic [DIR_W-1:0]     direction;
        logic [STATUS_W-1:0]  status;
        logic [ROW_OUT_W-1:0] start_row;
        logic [COL_OUT_W-1:0] start_col;
        logic [LABEL_W-1:0]   object_label;
    } step_res_t;

    // {decrement, increment} of the row for a chain code
    function automatic logic [1:0] dir_row_step(input logic [DIR_W-1:0] q);
        logic [1:0] mv;
        case (q)
            3'd1, 3'd2, 3'd3: mv = 2'b10;
            3'd5, 3'd6, 3'd7: mv = 2'b01;
            default:          mv = 2'b00;
        endcase
        return mv;
    endfunction

    // {decrement, increment} of the column for a chain code
    function automatic logic [1:0] dir_col_step(input logic [DIR_W-1:0] q);
        logic [1:0] mv;
        case (q)
            3'd0, 3'd1, 3'd7: mv = 2'b01;
            3'd3, 3'd4, 3'd5: mv = 2'b10;
            default:          mv = 2'b00;
        endcase
        return mv;
    endfunction

    function automatic logic [DIR_W-1:0] dir_remap(input logic [DIR_W-1:0] q);
        logic [DIR_W-1:0] d;
        case (q)
            3'd0, 3'd1: d = 3'd6;
            3'd2, 3'd3: d = 3'd0;
            3'd4, 3'd5: d = 3'd2;
            default:    d = 3'd4;
        endcase
        return d;
    endfunction

endpackage

// ===== design/ccct_if.sv =====
// ----------------------------------------------------------------------------
// ccct request and result channels
// Valid/ready channels carrying tracer requests and chain code results.
// ----------------------------------------------------------------------------
interface ccct_req_if;
    import ccct_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ccct_rsp_if;
    import ccct_pkg::*;

    logic      valid;
    logic      ready;
    step_res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/chain_code_contour_tracer_top.sv =====
// Load request: writes one pixel; the first nonzero pixel also starts the divider, which splits
// its raster index into the origin row and column while requests wait. Step request: probes issue
// in turn until one hits or the last misses; the next request is taken as the result appears.
// Neighbour probes stream through the single-port pixel memory, one read per cycle.
// A result waits in the output register while loads go on; a later step stalls behind it.
// Reset is asynchronous, active low, clears control and trace state; pixel memory is not cleared.
// ----------------------------------------------------------------------------
// chain_code_contour_tracer_top
// Freeman 8-direction chain code tracer over a raster-loaded labelled image.
// ----------------------------------------------------------------------------
module chain_code_contour_tracer_top #(
    parameter int MAX_ROWS   = ccct_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = ccct_pkg::MAX_COLS_DEF,
    parameter int PIXEL_BITS = ccct_pkg::PIXEL_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ccct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ccct_pkg::CFG_W-1:0]     cfg_wdata,
    ccct_req_if.sink                       req,
    ccct_rsp_if.source                     rsp
);
    import ccct_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LPW   = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int RXW   = RW + 1;
    localparam int CXW   = CW + 1;
    localparam int PW    = PIXEL_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SEARCH,
        S_RESULT
    } state_t;

    logic [CFG_W-1:0] rows_cfg_reg;
    logic [CFG_W-1:0] cols_cfg_reg;
    logic [RCW-1:0]   eff_rows;
    logic [CCW-1:0]   eff_cols;

    state_t            state_reg, state_next;
    logic [LPW-1:0]    load_pos_reg, load_pos_next;
    logic              start_seen_reg, start_seen_next;
    logic [RW-1:0]     origin_row_reg, origin_row_next;
    logic [CW-1:0]     origin_col_reg, origin_col_next;
    logic [PW-1:0]     label_reg, label_next;
    logic [RW-1:0]     here_row_reg, here_row_next;
    logic [CW-1:0]     here_col_reg, here_col_next;
    logic [DIR_W-1:0]  last_dir_reg, last_dir_next;
    logic              closed_reg, closed_next;

    logic [DIR_W-1:0]  iss_q_reg, iss_q_next;
    logic [3:0]        iss_k_reg, iss_k_next;
    logic              a_vld_reg, a_vld_next;
    logic [DIR_W-1:0]  a_q_reg, a_q_next;
    logic [2:0]        a_k_reg, a_k_next;
    logic [LPW-1:0]    a_addr_reg, a_addr_next;
    logic              a_inb_reg, a_inb_next;
    logic              r_vld_reg, r_vld_next;
    logic [DIR_W-1:0]  r_q_reg, r_q_next;
    logic [2:0]        r_k_reg, r_k_next;
    logic              r_ok_reg, r_ok_next;

    step_res_t         res_reg, res_next;
    logic              rsp_vld_reg, rsp_vld_next;
    step_res_t         rsp_data_reg, rsp_data_next;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [PW-1:0]     mem_wdata;
    logic [PW-1:0]     mem_rdata;

    logic              div_start;
    logic              div_done;
    logic [RW-1:0]     div_quo;
    logic [CW-1:0]     div_rem;

    logic [PW-1:0]     pix_in;
    logic [LPW-1:0]    total_pix;
    logic              can_load;
    logic [1:0]        p_rmv, p_cmv, h_rmv, h_cmv;
    logic [RXW-1:0]    probe_row;
    logic [CXW-1:0]    probe_col;
    logic              probe_inb;
    logic [LPW-1:0]    probe_addr;
    logic [RW-1:0]     hit_row;
    logic [CW-1:0]     hit_col;
    logic              hit, last_probe, stop;
    step_res_t         res_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= CFG_RESET;
            cols_cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS_IN_USE: rows_cfg_reg <= cfg_wdata;
                REG_COLS_IN_USE: cols_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (rows_cfg_reg == '0)
        begin
            eff_rows = RCW'(1);
        end
        else if (32'(rows_cfg_reg) > 32'(MAX_ROWS))
        begin
            eff_rows = RCW'(MAX_ROWS);
        end
        else
        begin
            eff_rows = RCW'(rows_cfg_reg);
        end
        if (cols_cfg_reg == '0)
        begin
            eff_cols = CCW'(1);
        end
        else if (32'(cols_cfg_reg) > 32'(MAX_COLS))
        begin
            eff_cols = CCW'(MAX_COLS);
        end
        else
        begin
            eff_cols = CCW'(cols_cfg_reg);
        end
    end

    assign pix_in    = PW'(req.payload.pixel_value);
    assign total_pix = LPW'(LPW'(eff_rows) * LPW'(eff_cols));
    assign can_load  = (load_pos_reg < total_pix);

    assign p_rmv      = dir_row_step(iss_q_reg);
    assign p_cmv      = dir_col_step(iss_q_reg);
    assign probe_row  = RXW'(here_row_reg) + RXW'(p_rmv[0]) - RXW'(p_rmv[1]);
    assign probe_col  = CXW'(here_col_reg) + CXW'(p_cmv[0]) - CXW'(p_cmv[1]);
    assign probe_inb  = !(p_rmv[1] && (here_row_reg == '0))
                     && !(p_cmv[1] && (here_col_reg == '0))
                     && (probe_row < RXW'(eff_rows))
                     && (probe_col < CXW'(eff_cols));
    assign probe_addr = LPW'(LPW'(probe_row[RW-1:0]) * LPW'(eff_cols))
                      + LPW'(probe_col[CW-1:0]);

    assign h_rmv   = dir_row_step(r_q_reg);
    assign h_cmv   = dir_col_step(r_q_reg);
    assign hit_row = here_row_reg + RW'(h_rmv[0]) - RW'(h_rmv[1]);
    assign hit_col = here_col_reg + CW'(h_cmv[0]) - CW'(h_cmv[1]);

    assign hit        = r_vld_reg && (r_ok_reg ? (mem_rdata == label_reg) : (label_reg == '0));
    assign last_probe = r_vld_reg && (r_k_reg == 3'd7);
    assign stop       = hit || last_probe;

    always_comb
    begin
        res_base.direction    = '0;
        res_base.status       = ST_STEP;
        res_base.start_row    = ROW_OUT_W'(origin_row_reg);
        res_base.start_col    = COL_OUT_W'(origin_col_reg);
        res_base.object_label = LABEL_W'(label_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        load_pos_next   = load_pos_reg;
        start_seen_next = start_seen_reg;
        origin_row_next = origin_row_reg;
        origin_col_next = origin_col_reg;
        label_next      = label_reg;
        here_row_next   = here_row_reg;
        here_col_next   = here_col_reg;
        last_dir_next   = last_dir_reg;
        closed_next     = closed_reg;
        iss_q_next      = iss_q_reg;
        iss_k_next      = iss_k_reg;
        a_vld_next      = 1'b0;
        a_q_next        = a_q_reg;
        a_k_next        = a_k_reg;
        a_addr_next     = a_addr_reg;
        a_inb_next      = a_inb_reg;
        r_vld_next      = 1'b0;
        r_q_next        = r_q_reg;
        r_k_next        = r_k_reg;
        r_ok_next       = r_ok_reg;
        res_next        = res_reg;
        rsp_vld_next    = rsp_vld_reg && !rsp.ready;
        rsp_data_next   = rsp_data_reg;
        mem_we          = 1'b0;
        mem_addr        = a_addr_reg[AW-1:0];
        mem_wdata       = pix_in;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.payload.command)
                        CMD_LOAD:
                        begin
                            if (can_load)
                            begin
                                mem_we        = 1'b1;
                                mem_addr      = load_pos_reg[AW-1:0];
                                load_pos_next = load_pos_reg + LPW'(1);
                                if (!start_seen_reg && (pix_in != '0))
                                begin
                                    start_seen_next = 1'b1;
                                    label_next      = pix_in;
                                    div_start       = 1'b1;
                                    state_next      = S_DIV;
                                end
                            end
                        end
                        CMD_STEP:
                        begin
                            if (!start_seen_reg)
                            begin
                                res_next        = res_base;
                                res_next.status = ST_NO_OBJECT;
                                state_next      = S_RESULT;
                            end
                            else if (closed_reg)
                            begin
                                res_next        = res_base;
                                res_next.status = ST_FINISHED;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                iss_q_next = last_dir_reg + DIR_W'(1);
                                iss_k_next = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_NEW:
                        begin
                            load_pos_next   = '0;
                            start_seen_next = 1'b0;
                            origin_row_next = '0;
                            origin_col_next = '0;
                            label_next      = '0;
                            here_row_next   = '0;
                            here_col_next   = '0;
                            last_dir_next   = DIR_RESET;
                            closed_next     = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    origin_row_next = div_quo;
                    origin_col_next = div_rem;
                    here_row_next   = div_quo;
                    here_col_next   = div_rem;
                    state_next      = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (stop)
                begin
                    res_next    = res_base;
                    closed_next = 1'b1;
                    if (hit)
                    begin
                        res_next.direction = r_q_reg;
                        here_row_next      = hit_row;
                        here_col_next      = hit_col;
                        last_dir_next      = dir_remap(r_q_reg);
                        if ((hit_row == origin_row_reg) && (hit_col == origin_col_reg))
                        begin
                            res_next.status = ST_CLOSE;
                        end
                        else
                        begin
                            res_next.status = ST_STEP;
                            closed_next     = 1'b0;
                        end
                    end
                    else
                    begin
                        res_next.status = ST_ISOLATED;
                    end
                    state_next = S_RESULT;
                end
                else
                begin
                    if (!iss_k_reg[3])
                    begin
                        a_vld_next  = 1'b1;
                        a_q_next    = iss_q_reg;
                        a_k_next    = iss_k_reg[2:0];
                        a_addr_next = probe_addr;
                        a_inb_next  = probe_inb;
                        iss_q_next  = iss_q_reg + DIR_W'(1);
                        iss_k_next  = iss_k_reg + 4'd1;
                    end
                    r_vld_next = a_vld_reg;
                    r_q_next   = a_q_reg;
                    r_k_next   = a_k_reg;
                    r_ok_next  = a_inb_reg && (a_addr_reg < load_pos_reg);
                end
            end
            S_RESULT:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    rsp_vld_next  = 1'b1;
                    rsp_data_next = res_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            load_pos_reg   <= '0;
            start_seen_reg <= 1'b0;
            origin_row_reg <= '0;
            origin_col_reg <= '0;
            label_reg      <= '0;
            here_row_reg   <= '0;
            here_col_reg   <= '0;
            last_dir_reg   <= DIR_RESET;
            closed_reg     <= 1'b0;
            iss_q_reg      <= '0;
            iss_k_reg      <= '0;
            a_vld_reg      <= 1'b0;
            a_q_reg        <= '0;
            a_k_reg        <= '0;
            a_addr_reg     <= '0;
            a_inb_reg      <= 1'b0;
            r_vld_reg      <= 1'b0;
            r_q_reg        <= '0;
            r_k_reg        <= '0;
            r_ok_reg       <= 1'b0;
            res_reg        <= '0;
            rsp_vld_reg    <= 1'b0;
            rsp_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_pos_reg   <= load_pos_next;
            start_seen_reg <= start_seen_next;
            origin_row_reg <= origin_row_next;
            origin_col_reg <= origin_col_next;
            label_reg      <= label_next;
            here_row_reg   <= here_row_next;
            here_col_reg   <= here_col_next;
            last_dir_reg   <= last_dir_next;
            closed_reg     <= closed_next;
            iss_q_reg      <= iss_q_next;
            iss_k_reg      <= iss_k_next;
            a_vld_reg      <= a_vld_next;
            a_q_reg        <= a_q_next;
            a_k_reg        <= a_k_next;
            a_addr_reg     <= a_addr_next;
            a_inb_reg      <= a_inb_next;
            r_vld_reg      <= r_vld_next;
            r_q_reg        <= r_q_next;
            r_k_reg        <= r_k_next;
            r_ok_reg       <= r_ok_next;
            res_reg        <= res_next;
            rsp_vld_reg    <= rsp_vld_next;
            rsp_data_reg   <= rsp_data_next;
        end
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_vld_reg;
    assign rsp.payload = rsp_data_reg;

    ccct_pixel_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW),
        .DATA_W (PW)
    ) u_pixel_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    ccct_divider #(
        .NUM_W (LPW),
        .DEN_W (CCW),
        .QUO_W (RW),
        .REM_W (CW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (load_pos_reg),
        .divisor   (eff_cols),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );
endmodule

// ===== design/ccct_pixel_mem.sv =====
// ----------------------------------------------------------------------------
// ccct_pixel_mem
// Single-port pixel memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ccct_pixel_mem #(
    parameter int DEPTH  = ccct_pkg::MAX_ROWS_DEF * ccct_pkg::MAX_COLS_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = ccct_pkg::PIXEL_BITS_DEF
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] pixel_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            pixel_array[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= pixel_array[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/ccct_divider.sv =====
// ----------------------------------------------------------------------------
// ccct_divider
// Restoring divider, one quotient bit per cycle, splits a raster index.
// ----------------------------------------------------------------------------
module ccct_divider #(
    parameter int NUM_W = 13,
    parameter int DEN_W = 7,
    parameter int QUO_W = 6,
    parameter int REM_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient,
    output logic [REM_W-1:0] remainder
);
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic             fits;

    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W);
            rem_next  = dividend;
            dsh_next  = NUM_W'(divisor) << (QUO_W - 1);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = QUO_W'({quo_reg, fits});
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dsh_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            dsh_reg  <= dsh_next;
            quo_reg  <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[REM_W-1:0];
endmodule

// ===== design/ccct_checker.sv =====
// ----------------------------------------------------------------------------
// ccct_checker
// Port-level checks of the contour tracer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccct_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic [ccct_pkg::CMD_W-1:0] req_command,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input ccct_pkg::step_res_t        rsp_payload
);
    import ccct_pkg::*;

    logic rsp_stall;
    logic no_object_shown;
    logic no_object_zero;
    logic end_status_shown;
    logic step_taken;

    assign rsp_stall        = rsp_valid && !rsp_ready;
    assign no_object_shown  = rsp_valid && (rsp_payload.status == ST_NO_OBJECT);
    assign no_object_zero   = (rsp_payload.direction == '0) && (rsp_payload.start_row == '0)
                           && (rsp_payload.start_col == '0) && (rsp_payload.object_label == '0);
    assign end_status_shown = rsp_valid && ((rsp_payload.status == ST_ISOLATED)
                                         || (rsp_payload.status == ST_FINISHED));
    assign step_taken       = req_valid && req_ready && (req_command == CMD_STEP);

    `CCCT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid && $stable(rsp_payload))
    `CCCT_ASSERT_IMP(a_no_object_zero, clk, rst_n, no_object_shown, no_object_zero)
    `CCCT_ASSERT_IMP(a_end_dir_zero, clk, rst_n, end_status_shown, rsp_payload.direction == '0)
    `CCCT_ASSERT_NEXT(a_step_busy, clk, rst_n, step_taken, !req_ready)
endmodule

bind chain_code_contour_tracer_top ccct_checker u_ccct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_command (req.payload.command),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
